/* design/lrsa_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and sizes for the label region statistics accumulator
package lrsa_pkg;

    // default sizes of the statistics store
    localparam int LABELS_DEF     = 255;
    localparam int VALUE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 24;

    // fixed payload widths
    localparam int OP_W     = 2;
    localparam int LABEL_W  = 8;
    localparam int VALUE_W  = 32;
    localparam int OCOUNT_W = 24;
    localparam int SUM_W    = 56;

    // command queue depth, a power of two
    localparam int CMDQ_DEPTH = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_ACC   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // saturation limits of the sum
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // command kinds after classification
    typedef enum logic [1:0] {
        K_ACC,
        K_READ,
        K_CLEAR
    } t_kind;

    // back end sequencer states
    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_EXEC
    } t_back_state;

    // input transaction
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [LABEL_W-1:0] label;
        logic [VALUE_W-1:0] value;
    } t_item;

    // result transaction
    typedef struct packed {
        logic [OCOUNT_W-1:0] voxel_count;
        logic [SUM_W-1:0]    value_sum;
        logic [VALUE_W-1:0]  minimum;
        logic [VALUE_W-1:0]  maximum;
        logic                empty_res;
        logic [LABEL_W-1:0]  highest_label;
    } t_result;

    // classified command handed from front to back
    typedef struct packed {
        t_kind              kind;
        logic               in_range;
        logic [LABEL_W-1:0] label;
        logic [VALUE_W-1:0] value;
    } t_cmd;

endpackage

/* design/lrsa_front.sv */
`timescale 1ns / 1ps
// front end: accepts items, classifies them and queues commands for the back end
module lrsa_front #(
    parameter int LABELS     = lrsa_pkg::LABELS_DEF,
    parameter int VALUE_BITS = lrsa_pkg::VALUE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  lrsa_pkg::t_item i_item,
    output logic            o_cmd_valid,
    output lrsa_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_take
);

    localparam int DEPTH = lrsa_pkg::CMDQ_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lrsa_pkg::t_cmd r_queue [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    lrsa_pkg::t_cmd w_cmd;
    logic           w_keep;
    logic           w_enq, w_deq;

    // classify: drop unused codes and accumulates that change nothing
    always_comb begin
        w_cmd.label    = i_item.label;
        w_cmd.value    = lrsa_pkg::VALUE_W'($signed(i_item.value[VALUE_BITS-1:0]));
        w_cmd.in_range = (i_item.label != '0) &&
                         ({1'b0, i_item.label} <= (lrsa_pkg::LABEL_W+1)'(LABELS));
        w_cmd.kind     = lrsa_pkg::K_ACC;
        w_keep         = 1'b0;
        case (i_item.op)
            lrsa_pkg::OP_ACC: begin
                w_cmd.kind = lrsa_pkg::K_ACC;
                w_keep     = w_cmd.in_range;
            end
            lrsa_pkg::OP_READ: begin
                w_cmd.kind = lrsa_pkg::K_READ;
                w_keep     = 1'b1;
            end
            lrsa_pkg::OP_CLEAR: begin
                w_cmd.kind = lrsa_pkg::K_CLEAR;
                w_keep     = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    // queue handshake
    assign full        = (r_count == CNT_W'(DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign w_enq       = push && !full && w_keep;
    assign w_deq       = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_count = r_count;
        if (w_enq && !w_deq) begin
            n_count = r_count + 1'b1;
        end else if (!w_enq && w_deq) begin
            n_count = r_count - 1'b1;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_enq) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_deq) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

/* design/lrsa_back.sv */
`timescale 1ns / 1ps
// back end: per-label statistics store, read-modify-write sequencer and result register
module lrsa_back #(
    parameter int LABELS     = lrsa_pkg::LABELS_DEF,
    parameter int VALUE_BITS = lrsa_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = lrsa_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  lrsa_pkg::t_cmd    i_cmd,
    output logic              o_cmd_take,
    output logic              empty,
    input  logic              pop,
    output lrsa_pkg::t_result o_result
);

    localparam int IDX_W = (LABELS > 1) ? $clog2(LABELS) : 1;
    localparam int SW    = lrsa_pkg::SUM_W;

    // statistics memories
    logic [COUNT_BITS-1:0]        mem_count [LABELS];
    logic [SW-1:0]                mem_sum   [LABELS];
    logic signed [VALUE_BITS-1:0] mem_min   [LABELS];
    logic signed [VALUE_BITS-1:0] mem_max   [LABELS];

    logic [COUNT_BITS-1:0]        r_rd_count;
    logic [SW-1:0]                r_rd_sum;
    logic signed [VALUE_BITS-1:0] r_rd_min, r_rd_max;

    logic [LABELS-1:0] r_valid;
    logic [lrsa_pkg::LABEL_W-1:0] r_max_label;

    lrsa_pkg::t_back_state r_state, n_state;

    // command held while it is carried out
    lrsa_pkg::t_kind              r_kind;
    logic                         r_in_range;
    logic [IDX_W-1:0]             r_idx;
    logic [lrsa_pkg::LABEL_W-1:0] r_label;
    logic signed [VALUE_BITS-1:0] r_value;

    logic              r_out_valid;
    lrsa_pkg::t_result r_out;

    logic [lrsa_pkg::LABEL_W-1:0] w_label_m1;
    logic                         w_take, w_mem_we, w_out_load, w_clear, w_can_load;
    logic                         w_hit;
    logic signed [SW:0]           w_sum_wide;
    logic [SW-1:0]                w_sum_sat;
    logic [COUNT_BITS-1:0]        w_new_count;
    logic [SW-1:0]                w_new_sum;
    logic signed [VALUE_BITS-1:0] w_new_min, w_new_max;
    logic [31:0]                  w_count_ext;
    lrsa_pkg::t_result            w_res;

    assign w_label_m1 = i_cmd.label - 1'b1;
    assign w_can_load = !r_out_valid || pop;
    assign w_hit      = r_in_range && r_valid[r_idx];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lrsa_pkg::B_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = lrsa_pkg::B_READ;
                end
            end
            lrsa_pkg::B_READ: begin
                n_state = lrsa_pkg::B_EXEC;
            end
            lrsa_pkg::B_EXEC: begin
                if (!(r_kind == lrsa_pkg::K_READ && !w_can_load)) begin
                    n_state = lrsa_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = lrsa_pkg::B_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_take     = 1'b0;
        w_mem_we   = 1'b0;
        w_out_load = 1'b0;
        w_clear    = 1'b0;
        case (r_state)
            lrsa_pkg::B_IDLE: begin
                w_take = i_cmd_valid;
            end
            lrsa_pkg::B_EXEC: begin
                w_mem_we   = (r_kind == lrsa_pkg::K_ACC);
                w_out_load = (r_kind == lrsa_pkg::K_READ) && w_can_load;
                w_clear    = (r_kind == lrsa_pkg::K_CLEAR);
            end
            default: begin
                w_take = 1'b0;
            end
        endcase
    end

    assign o_cmd_take = w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrsa_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latch the command taken from the queue
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_kind     <= i_cmd.kind;
            r_in_range <= i_cmd.in_range;
            r_idx      <= w_label_m1[IDX_W-1:0];
            r_label    <= i_cmd.label;
            r_value    <= i_cmd.value[VALUE_BITS-1:0];
        end
    end

    // registered memory read of the held label
    always_ff @(posedge i_clk) begin
        r_rd_count <= mem_count[r_idx];
        r_rd_sum   <= mem_sum[r_idx];
        r_rd_min   <= mem_min[r_idx];
        r_rd_max   <= mem_max[r_idx];
    end

    // saturating sum
    always_comb begin
        w_sum_wide = $signed({r_rd_sum[SW-1], r_rd_sum}) + (SW+1)'(r_value);
        case (w_sum_wide[SW:SW-1])
            2'b01:   w_sum_sat = lrsa_pkg::SUM_MAX;
            2'b10:   w_sum_sat = lrsa_pkg::SUM_MIN;
            default: w_sum_sat = w_sum_wide[SW-1:0];
        endcase
    end

    // updated entry, first voxel loads fresh values
    always_comb begin
        if (w_hit) begin
            w_new_count = (r_rd_count == '1) ? r_rd_count : r_rd_count + 1'b1;
            w_new_sum   = w_sum_sat;
            w_new_min   = (r_value < r_rd_min) ? r_value : r_rd_min;
            w_new_max   = (r_value > r_rd_max) ? r_value : r_rd_max;
        end else begin
            w_new_count = COUNT_BITS'(1);
            w_new_sum   = SW'(r_value);
            w_new_min   = r_value;
            w_new_max   = r_value;
        end
    end

    // memory write
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_count[r_idx] <= w_new_count;
            mem_sum[r_idx]   <= w_new_sum;
            mem_min[r_idx]   <= w_new_min;
            mem_max[r_idx]   <= w_new_max;
        end
    end

    // valid bits and highest label
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_max_label <= '0;
        end else if (w_clear) begin
            r_valid     <= '0;
            r_max_label <= '0;
        end else if (w_mem_we) begin
            r_valid[r_idx] <= 1'b1;
            if (r_label > r_max_label) begin
                r_max_label <= r_label;
            end
        end
    end

    // result formatting, empty labels read as zero
    always_comb begin
        w_count_ext         = 32'(r_rd_count);
        w_res.highest_label = r_max_label;
        w_res.empty_res     = !w_hit;
        if (w_hit) begin
            w_res.voxel_count = w_count_ext[lrsa_pkg::OCOUNT_W-1:0];
            w_res.value_sum   = r_rd_sum;
            w_res.minimum     = lrsa_pkg::VALUE_W'(r_rd_min);
            w_res.maximum     = lrsa_pkg::VALUE_W'(r_rd_max);
        end else begin
            w_res.voxel_count = '0;
            w_res.value_sum   = '0;
            w_res.minimum     = '0;
            w_res.maximum     = '0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_res;
        end
    end

    assign empty    = !r_out_valid;
    assign o_result = r_out;

endmodule

/* design/label_region_stats_accumulator_core.sv */
`timescale 1ns / 1ps
// top level: label region statistics accumulator
// a read result passes the command queue, the command latch, the registered memory read
// and the result register; each transaction uses the read-modify-write sequencer
//   around the single-port statistics memory (take, read, execute) before the next
// a two-entry command queue keeps taking transactions while a result waits, until full
// reset: synchronous active low; empties queue and result register, drops all valid bits
module label_region_stats_accumulator_core #(
    parameter int LABELS     = lrsa_pkg::LABELS_DEF,
    parameter int VALUE_BITS = lrsa_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = lrsa_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  lrsa_pkg::t_item   i_item,
    output logic              empty,
    input  logic              pop,
    output lrsa_pkg::t_result o_result
);

    logic           w_cmd_valid;
    logic           w_cmd_take;
    lrsa_pkg::t_cmd w_cmd;

    // classification and command queue
    lrsa_front #(
        .LABELS     (LABELS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    // statistics store and result register
    lrsa_back #(
        .LABELS     (LABELS),
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

/* design/lrsa_checker.sv */
`timescale 1ns / 1ps
// port-level checker for the label region statistics accumulator, with its bind
module lrsa_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input lrsa_pkg::t_item   i_item,
    input logic              empty,
    input logic              pop,
    input lrsa_pkg::t_result o_result
);

    // reset leaves both queues empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // a waiting result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");

    // input side fills only on a push
    a_full_by_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without a push");

    // an empty label reports zero statistics
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.empty_res) |->
        (o_result.voxel_count == '0 && o_result.value_sum == '0 &&
         o_result.minimum == '0 && o_result.maximum == '0))
        else $error("empty label with nonzero statistics");

    // a filled label has voxels, an ordered range and a nonzero highest label
    a_filled_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.empty_res) |->
        (o_result.voxel_count != '0 && o_result.highest_label != '0 &&
         $signed(o_result.minimum) <= $signed(o_result.maximum)))
        else $error("filled label with inconsistent statistics");

endmodule

bind label_region_stats_accumulator_core lrsa_checker u_lrsa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .i_item   (i_item),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

/* bench/tb.sv */
`timescale 1ns / 1ps
// testbench for the label region statistics accumulator: predicted per-label stats vs dut
module tb;
    import lrsa_pkg::*;

    // unused op code, must be ignored by the block
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int     NUM_LABELS   = LABELS_DEF;
    localparam int     RANDOM_ITEMS = 1150;
    localparam int     IDLE_LIMIT   = 4000;
    localparam int     TAIL_CYCLES  = 16;
    localparam longint SUM_HI       = (64'sd1 <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO       = -SUM_HI - 1;

    // one queued voxel command with its lead-in gap
    typedef struct {
        t_item       item;
        int unsigned gap;
        bit          drain;
    } t_stim;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    push    = 1'b0;
    logic    full;
    t_item   i_item  = '0;
    logic    empty;
    logic    pop     = 1'b0;
    t_result o_result;

    label_region_stats_accumulator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    // commands waiting to be driven and statistics due back from reads
    t_stim   voxel_cmd_q[$];
    t_result stats_due_q[$];

    // predicted per-label statistics
    bit                          lbl_valid [1:NUM_LABELS];
    logic [COUNT_BITS_DEF-1:0]   lbl_count [1:NUM_LABELS];
    logic signed [SUM_W-1:0]     lbl_sum   [1:NUM_LABELS];
    logic signed [VALUE_W-1:0]   lbl_min   [1:NUM_LABELS];
    logic signed [VALUE_W-1:0]   lbl_max   [1:NUM_LABELS];
    logic [LABEL_W-1:0]          top_label;

    int unsigned error_count   = 0;
    int unsigned reads_checked = 0;

    // handshake history, sampled at the rising edge
    bit item_took   = 1'b0;
    bit result_took = 1'b0;

    // driver and receiver state
    t_stim       cur_cmd;
    bit          cur_live      = 1'b0;
    int unsigned gap_left      = 0;
    int unsigned stall_left    = 0;
    int unsigned results_taken = 0;
    bit          rx_calm       = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns, read %0d: %s", $time, reads_checked, msg);
        error_count++;
    endtask

    // update the predicted store for one accepted transaction
    task automatic apply_to_stats(input t_item it);
        t_result                 r;
        logic signed [VALUE_W-1:0] v;
        longint                  total;
        int                      id;
        v  = it.value;
        id = int'(it.label);
        case (it.op)
            OP_ACC: begin
                if (id != 0 && id <= NUM_LABELS) begin
                    if (!lbl_valid[id]) begin
                        lbl_valid[id] = 1'b1;
                        lbl_count[id] = COUNT_BITS_DEF'(1);
                        lbl_sum[id]   = SUM_W'(v);
                        lbl_min[id]   = v;
                        lbl_max[id]   = v;
                    end else begin
                        total = longint'(lbl_sum[id]) + longint'(v);
                        if (total > SUM_HI) total = SUM_HI;
                        if (total < SUM_LO) total = SUM_LO;
                        lbl_sum[id] = total[SUM_W-1:0];
                        if (lbl_count[id] != '1) lbl_count[id] = lbl_count[id] + 1'b1;
                        if (v < lbl_min[id]) lbl_min[id] = v;
                        if (v > lbl_max[id]) lbl_max[id] = v;
                    end
                    if (it.label > top_label) top_label = it.label;
                end
            end
            OP_READ: begin
                r = '0;
                if (id != 0 && id <= NUM_LABELS && lbl_valid[id]) begin
                    r.voxel_count = lbl_count[id][OCOUNT_W-1:0];
                    r.value_sum   = lbl_sum[id];
                    r.minimum     = lbl_min[id];
                    r.maximum     = lbl_max[id];
                end else begin
                    r.empty_res = 1'b1;
                end
                r.highest_label = top_label;
                stats_due_q.push_back(r);
            end
            OP_CLEAR: begin
                for (int k = 1; k <= NUM_LABELS; k++) lbl_valid[k] = 1'b0;
                top_label = '0;
            end
            default: ;
        endcase
    endtask

    // compare one popped result against the oldest expected statistics
    task automatic compare_stats(input t_result got);
        t_result want;
        if (stats_due_q.size() == 0) begin
            report_mismatch("result with no read pending");
            return;
        end
        want = stats_due_q.pop_front();
        reads_checked++;
        if (got.voxel_count !== want.voxel_count)
            report_mismatch($sformatf("voxel_count %h, want %h", got.voxel_count,
                                      want.voxel_count));
        if (got.value_sum !== want.value_sum)
            report_mismatch($sformatf("value_sum %h, want %h", got.value_sum, want.value_sum));
        if (got.minimum !== want.minimum)
            report_mismatch($sformatf("minimum %h, want %h", got.minimum, want.minimum));
        if (got.maximum !== want.maximum)
            report_mismatch($sformatf("maximum %h, want %h", got.maximum, want.maximum));
        if (got.empty_res !== want.empty_res)
            report_mismatch($sformatf("empty_res %b, want %b", got.empty_res, want.empty_res));
        if (got.highest_label !== want.highest_label)
            report_mismatch($sformatf("highest_label %0d, want %0d", got.highest_label,
                                      want.highest_label));
    endtask

    task automatic queue_item(input logic [OP_W-1:0] op, input logic [LABEL_W-1:0] label,
                              input logic [VALUE_W-1:0] value, input int unsigned gap,
                              input bit drain);
        t_stim s;
        s.item.op    = op;
        s.item.label = label;
        s.item.value = value;
        s.gap        = gap;
        s.drain      = drain;
        voxel_cmd_q.push_back(s);
    endtask

    // mostly a small hot set of labels so reads find filled entries
    function automatic logic [LABEL_W-1:0] pick_label();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return LABEL_W'($urandom_range(0, 255));
            3, 4, 5: return LABEL_W'($urandom_range(244, 255));
            default: return LABEL_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 7) != 0) return $urandom;
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0001;
            default: return '0;
        endcase
    endfunction

    // sample handshakes, check results, and predict
    always @(posedge i_clk) begin
        item_took   <= i_rst_n && push && !full;
        result_took <= i_rst_n && pop && !empty;
        if (i_rst_n) begin
            if (pop && !empty) compare_stats(o_result);
            if (push && !full) apply_to_stats(i_item);
        end
    end

    // driver: one transaction at a time, new item after the current one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !item_took) begin
            // hold until the block takes it
        end else begin
            if (push) cur_live = 1'b0;
            if (!cur_live && voxel_cmd_q.size() != 0) begin
                cur_cmd  = voxel_cmd_q.pop_front();
                gap_left = cur_cmd.gap;
                cur_live = 1'b1;
            end
            if (cur_live && gap_left == 0 && !(cur_cmd.drain && stats_due_q.size() != 0)) begin
                push   <= 1'b1;
                i_item <= cur_cmd.item;
            end else begin
                push <= 1'b0;
                if (cur_live && gap_left != 0) gap_left--;
            end
        end
    end

    // receiver: random stall before each result, calm stretches in between
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop && !result_took) begin
            // keep waiting for a result
        end else begin
            if (pop) begin
                results_taken++;
                if (results_taken % 24 == 0) rx_calm = ($urandom_range(0, 2) == 0);
                stall_left = rx_calm ? 0 : $urandom_range(0, 14);
            end
            if (stall_left == 0) begin
                pop <= 1'b1;
            end else begin
                pop <= 1'b0;
                stall_left--;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty)) idle = 0;
            else idle++;
        end
        $display("tb: errors");
        $finish;
    end

    initial begin : stimulus
        int unsigned      counted;
        int unsigned      seg;
        int unsigned      tx_mode;
        int unsigned      pick;
        int unsigned      gap;
        logic [OP_W-1:0]    op;
        logic [LABEL_W-1:0] label;

        for (int k = 1; k <= NUM_LABELS; k++) begin
            lbl_valid[k] = 1'b0;
            lbl_count[k] = '0;
            lbl_sum[k]   = '0;
            lbl_min[k]   = '0;
            lbl_max[k]   = '0;
        end
        top_label = '0;

        // directed: empty reads, background, extremes, forwarding, spare op, clear
        queue_item(OP_READ,  8'd0,   32'h0000_0000, 0, 1'b0);
        queue_item(OP_READ,  8'd255, 32'hffff_ffff, 0, 1'b0);
        queue_item(OP_ACC,   8'd0,   32'h7fff_ffff, 0, 1'b0);
        queue_item(OP_ACC,   8'd1,   32'h8000_0000, 0, 1'b0);
        queue_item(OP_ACC,   8'd1,   32'h7fff_ffff, 0, 1'b0);
        queue_item(OP_ACC,   8'd1,   32'h0000_0000, 0, 1'b0);
        queue_item(OP_READ,  8'd1,   32'h0000_0000, 0, 1'b0);
        queue_item(OP_ACC,   8'd255, 32'hffff_ffff, 3, 1'b0);
        queue_item(OP_ACC,   8'd255, 32'hffff_ffff, 0, 1'b0);
        queue_item(OP_READ,  8'd255, 32'h0000_0000, 0, 1'b0);
        queue_item(OP_READ,  8'd0,   32'h0000_0000, 5, 1'b0);
        queue_item(OP_SPARE, 8'd1,   32'h1234_5678, 0, 1'b0);
        queue_item(OP_READ,  8'd1,   32'h0000_0000, 0, 1'b0);
        queue_item(OP_CLEAR, 8'd0,   32'h0000_0000, 0, 1'b1);
        queue_item(OP_READ,  8'd1,   32'h0000_0000, 0, 1'b0);
        queue_item(OP_READ,  8'd255, 32'h0000_0000, 2, 1'b0);
        queue_item(OP_ACC,   8'd128, 32'h1234_5678, 0, 1'b0);
        queue_item(OP_READ,  8'd128, 32'h0000_0000, 0, 1'b0);
        queue_item(OP_ACC,   8'd2,   32'h0001_0000, 0, 1'b0);
        queue_item(OP_ACC,   8'd2,   32'hffff_0000, 0, 1'b0);
        queue_item(OP_READ,  8'd2,   32'h0000_0000, 0, 1'b0);
        queue_item(OP_ACC,   8'd85,  32'h5555_5555, 0, 1'b0);
        queue_item(OP_ACC,   8'd170, 32'haaaa_aaaa, 0, 1'b0);
        queue_item(OP_READ,  8'd85,  32'h0000_0000, 0, 1'b0);
        queue_item(OP_READ,  8'd170, 32'h0000_0000, 0, 1'b0);

        // random: mostly accumulates and reads on hot labels, rare clears and spare ops
        counted = 0;
        seg     = 0;
        tx_mode = 0;
        while (counted < RANDOM_ITEMS) begin
            if (seg == 0) begin
                tx_mode = $urandom_range(0, 2);
                seg     = 40;
            end
            seg--;
            pick = $urandom_range(0, 99);
            if (pick < 2) op = OP_SPARE;
            else if (pick < 4) op = OP_CLEAR;
            else if (pick < 40) op = OP_READ;
            else op = OP_ACC;
            label = pick_label();
            if (tx_mode == 0) gap = 0;
            else if (tx_mode == 1) gap = $urandom_range(0, 14);
            else gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 14) : 0;
            queue_item(op, label, pick_value(), gap,
                       ($urandom_range(0, 149) == 0) || counted == RANDOM_ITEMS / 2);
            counted++;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (voxel_cmd_q.size() != 0 || cur_live) @(posedge i_clk);
        while (stats_due_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

endmodule
